// ----- rtl/vfv_pkg.sv -----
// ----------------------------------------------------------------------------
// vfv_pkg: shared types and microcode for the voxel face visibility block
// Control word layout, sequencer program, voxel id constants and status codes.
// ----------------------------------------------------------------------------
package vfv_pkg;

    // default chunk geometry
    localparam int CHUNK_WIDTH_DEF  = 16;
    localparam int CHUNK_HEIGHT_DEF = 64;

    // voxel ids with a meaning of their own
    localparam logic [7:0] ID_AIR    = 8'd0;
    localparam logic [7:0] ID_GROUND = 8'd2;
    localparam logic [7:0] ID_WATER  = 8'd10;

    // layers below this one come out of reset as ground
    localparam int GROUND_LAYERS = 23;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SAME    = 2'd2
    } status_t;

    // read address selection: the voxel itself or one of its six neighbors
    typedef enum logic [2:0] {
        DIR_NONE = 3'd0,
        DIR_SELF = 3'd1,
        DIR_XP   = 3'd2,
        DIR_YP   = 3'd3,
        DIR_ZP   = 3'd4,
        DIR_XN   = 3'd5,
        DIR_YN   = 3'd6,
        DIR_ZN   = 3'd7
    } dir_t;

    // where the word read in the previous step is captured
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_SELF = 3'd1,
        CAP_F0   = 3'd2,
        CAP_F1   = 3'd3,
        CAP_F2   = 3'd4,
        CAP_F3   = 3'd5,
        CAP_F4   = 3'd6,
        CAP_F5   = 3'd7
    } cap_t;

    // result produced by a step
    typedef enum logic [2:0] {
        RES_NONE  = 3'd0,
        RES_INV   = 3'd1,
        RES_ZERO  = 3'd2,
        RES_NEW   = 3'd3,
        RES_SAME  = 3'd4,
        RES_QUERY = 3'd5
    } res_t;

    // sequencing of the step counter
    typedef enum logic [1:0] {
        JMP_DISPATCH = 2'd0,
        JMP_NEXT     = 2'd1,
        JMP_GOTO     = 2'd2,
        JMP_SAME     = 2'd3
    } jmp_t;

    typedef logic [3:0] pc_t;

    // program addresses
    localparam pc_t PC_IDLE  = 4'd0;
    localparam pc_t PC_INV   = 4'd1;
    localparam pc_t PC_NOP   = 4'd2;
    localparam pc_t PC_CLR   = 4'd3;
    localparam pc_t PC_W0    = 4'd4;
    localparam pc_t PC_W1    = 4'd5;
    localparam pc_t PC_WNEW  = 4'd6;
    localparam pc_t PC_WSAME = 4'd7;
    localparam pc_t PC_Q0    = 4'd8;
    localparam pc_t PC_Q1    = 4'd9;
    localparam pc_t PC_Q2    = 4'd10;
    localparam pc_t PC_Q3    = 4'd11;
    localparam pc_t PC_Q4    = 4'd12;
    localparam pc_t PC_Q5    = 4'd13;

    typedef struct packed {
        dir_t rd_a;
        dir_t rd_b;
        cap_t cap_a;
        cap_t cap_b;
        logic wr_en;
        logic dirty_set;
        logic dirty_clr;
        res_t res;
        jmp_t jmp;
        pc_t  target;
    } ctrl_t;

    // status seen by the sequencer
    typedef struct packed {
        logic       accept;
        logic [1:0] kind;
        logic       coord_ok;
        logic       same_id;
        logic       out_free;
        logic       init_busy;
    } seq_in_t;

    // control store
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        w.rd_a      = DIR_NONE;
        w.rd_b      = DIR_NONE;
        w.cap_a     = CAP_NONE;
        w.cap_b     = CAP_NONE;
        w.wr_en     = 1'b0;
        w.dirty_set = 1'b0;
        w.dirty_clr = 1'b0;
        w.res       = RES_NONE;
        w.jmp       = JMP_GOTO;
        w.target    = PC_IDLE;
        unique case (pc)
            PC_IDLE:  w.jmp = JMP_DISPATCH;
            PC_INV:   w.res = RES_INV;
            PC_NOP:   w.res = RES_ZERO;
            PC_CLR:
            begin
                w.dirty_clr = 1'b1;
                w.res       = RES_ZERO;
            end
            PC_W0:
            begin
                w.rd_a = DIR_SELF;
                w.jmp  = JMP_NEXT;
            end
            PC_W1:
            begin
                w.jmp    = JMP_SAME;
                w.target = PC_WSAME;
            end
            PC_WNEW:
            begin
                w.wr_en     = 1'b1;
                w.dirty_set = 1'b1;
                w.res       = RES_NEW;
            end
            PC_WSAME: w.res = RES_SAME;
            PC_Q0:
            begin
                w.rd_a = DIR_SELF;
                w.rd_b = DIR_XP;
                w.jmp  = JMP_NEXT;
            end
            PC_Q1:
            begin
                w.rd_a  = DIR_YP;
                w.rd_b  = DIR_ZP;
                w.cap_a = CAP_SELF;
                w.cap_b = CAP_F0;
                w.jmp   = JMP_NEXT;
            end
            PC_Q2:
            begin
                w.rd_a  = DIR_XN;
                w.rd_b  = DIR_YN;
                w.cap_a = CAP_F1;
                w.cap_b = CAP_F2;
                w.jmp   = JMP_NEXT;
            end
            PC_Q3:
            begin
                w.rd_a  = DIR_ZN;
                w.cap_a = CAP_F3;
                w.cap_b = CAP_F4;
                w.jmp   = JMP_NEXT;
            end
            PC_Q4:
            begin
                w.cap_a = CAP_F5;
                w.jmp   = JMP_NEXT;
            end
            PC_Q5:    w.res = RES_QUERY;
            default:  w.jmp = JMP_GOTO;
        endcase
        return w;
    endfunction

    // one-hot face slot written by a capture code
    function automatic logic [5:0] cap_face(input cap_t c);
        logic [5:0] f;
        f = 6'b000000;
        unique case (c)
            CAP_F0:  f = 6'b000001;
            CAP_F1:  f = 6'b000010;
            CAP_F2:  f = 6'b000100;
            CAP_F3:  f = 6'b001000;
            CAP_F4:  f = 6'b010000;
            CAP_F5:  f = 6'b100000;
            default: f = 6'b000000;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/vfv_store.sv -----
// ----------------------------------------------------------------------------
// vfv_store: voxel memory with neighbor address generation
// One write port and two registered read ports; fills itself with the
// ground/air pattern after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module vfv_store #(
    parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(CHUNK_WIDTH)-1:0]    pos_x,
    input  logic [$clog2(CHUNK_HEIGHT)-1:0]   pos_y,
    input  logic [$clog2(CHUNK_WIDTH)-1:0]    pos_z,
    input  vfv_pkg::dir_t                     rd_a_dir,
    input  vfv_pkg::dir_t                     rd_b_dir,
    input  logic                              wr_en,
    input  logic [7:0]                        wr_data,
    output logic [7:0]                        rd_a_data,
    output logic                              rd_a_bnd,
    output logic [7:0]                        rd_b_data,
    output logic                              rd_b_bnd,
    output logic                              init_busy
);

    localparam int XW    = $clog2(CHUNK_WIDTH);
    localparam int YW    = $clog2(CHUNK_HEIGHT);
    localparam int AW    = 2 * XW + YW;
    localparam int DEPTH = 1 << AW;

    logic [7:0]    voxel_mem [DEPTH];
    logic [AW-1:0] init_cnt_reg;
    logic [AW-1:0] init_cnt_next;
    logic          init_busy_reg;
    logic          init_busy_next;
    logic [7:0]    init_val;
    logic [AW-1:0] self_addr;
    logic [AW:0]   a_sel;
    logic [AW:0]   b_sel;
    logic [7:0]    rd_a_data_reg;
    logic          rd_a_bnd_reg;
    logic [7:0]    rd_b_data_reg;
    logic          rd_b_bnd_reg;

    // neighbor address, with a flag for a neighbor beyond the chunk boundary
    function automatic logic [AW:0] nbr_addr(
        input vfv_pkg::dir_t  d,
        input logic [XW-1:0]  x,
        input logic [YW-1:0]  y,
        input logic [XW-1:0]  z
    );
        logic [XW-1:0] nx;
        logic [YW-1:0] ny;
        logic [XW-1:0] nz;
        logic          bnd;
        nx  = x;
        ny  = y;
        nz  = z;
        bnd = 1'b0;
        unique case (d)
            vfv_pkg::DIR_XP:
            begin
                nx  = x + 1'b1;
                bnd = (x == XW'(CHUNK_WIDTH - 1));
            end
            vfv_pkg::DIR_YP:
            begin
                ny  = y + 1'b1;
                bnd = (y == YW'(CHUNK_HEIGHT - 1));
            end
            vfv_pkg::DIR_ZP:
            begin
                nz  = z + 1'b1;
                bnd = (z == XW'(CHUNK_WIDTH - 1));
            end
            vfv_pkg::DIR_XN:
            begin
                nx  = x - 1'b1;
                bnd = (x == '0);
            end
            vfv_pkg::DIR_YN:
            begin
                ny  = y - 1'b1;
                bnd = (y == '0);
            end
            vfv_pkg::DIR_ZN:
            begin
                nz  = z - 1'b1;
                bnd = (z == '0);
            end
            default:
            begin
                bnd = 1'b0;
            end
        endcase
        return {bnd, nx, ny, nz};
    endfunction

    // address generation for both read ports
    assign self_addr = {pos_x, pos_y, pos_z};
    assign a_sel     = nbr_addr(rd_a_dir, pos_x, pos_y, pos_z);
    assign b_sel     = nbr_addr(rd_b_dir, pos_x, pos_y, pos_z);

    // clearing pass: ground below the ground layers, air above
    assign init_val = (init_cnt_reg[XW +: YW] < YW'(vfv_pkg::GROUND_LAYERS)) ?
                      vfv_pkg::ID_GROUND : vfv_pkg::ID_AIR;

    always_comb
    begin
        init_cnt_next  = init_cnt_reg;
        init_busy_next = init_busy_reg;
        if (init_busy_reg)
        begin
            init_cnt_next = init_cnt_reg + 1'b1;
            if (init_cnt_reg == '1)
            begin
                init_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            init_busy_reg <= 1'b1;
        end
        else
        begin
            init_cnt_reg  <= init_cnt_next;
            init_busy_reg <= init_busy_next;
        end
    end

    // memory array: one write port, two read ports with registered data
    always_ff @(posedge clk)
    begin
        if (init_busy_reg)
        begin
            voxel_mem[init_cnt_reg] <= init_val;
        end
        else if (wr_en)
        begin
            voxel_mem[self_addr] <= wr_data;
        end
        if (rd_a_dir != vfv_pkg::DIR_NONE)
        begin
            rd_a_data_reg <= voxel_mem[a_sel[AW-1:0]];
            rd_a_bnd_reg  <= a_sel[AW];
        end
        if (rd_b_dir != vfv_pkg::DIR_NONE)
        begin
            rd_b_data_reg <= voxel_mem[b_sel[AW-1:0]];
            rd_b_bnd_reg  <= b_sel[AW];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_a_bnd  = rd_a_bnd_reg;
    assign rd_b_data = rd_b_data_reg;
    assign rd_b_bnd  = rd_b_bnd_reg;
    assign init_busy = init_busy_reg;

endmodule

// ----- rtl/vfv_seq.sv -----
// ----------------------------------------------------------------------------
// vfv_seq: microcode sequencer
// Step counter over the control store, with dispatch on item kind and
// conditional jumps; holds on a result step until the output slot is free.
// ----------------------------------------------------------------------------
module vfv_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  vfv_pkg::seq_in_t st,
    output vfv_pkg::ctrl_t   ctrl,
    output logic             step_go,
    output logic             in_ready
);

    vfv_pkg::pc_t pc_reg;
    vfv_pkg::pc_t pc_next;
    vfv_pkg::pc_t entry;

    // control word of the current step
    assign ctrl = vfv_pkg::ucode(pc_reg);

    // a result step waits for the output register
    assign step_go  = (ctrl.res == vfv_pkg::RES_NONE) || st.out_free;
    assign in_ready = (ctrl.jmp == vfv_pkg::JMP_DISPATCH) && !st.init_busy;

    // program entry for the accepted item
    always_comb
    begin
        priority if (st.kind == vfv_pkg::KIND_CLEAR)
        begin
            entry = vfv_pkg::PC_CLR;
        end
        else if ((st.kind == vfv_pkg::KIND_WRITE || st.kind == vfv_pkg::KIND_QUERY)
                 && !st.coord_ok)
        begin
            entry = vfv_pkg::PC_INV;
        end
        else if (st.kind == vfv_pkg::KIND_WRITE)
        begin
            entry = vfv_pkg::PC_W0;
        end
        else if (st.kind == vfv_pkg::KIND_QUERY)
        begin
            entry = vfv_pkg::PC_Q0;
        end
        else
        begin
            entry = vfv_pkg::PC_NOP;
        end
    end

    // next step
    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.jmp)
            vfv_pkg::JMP_DISPATCH:
            begin
                if (st.accept)
                begin
                    pc_next = entry;
                end
            end
            vfv_pkg::JMP_NEXT:
            begin
                if (step_go)
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            vfv_pkg::JMP_GOTO:
            begin
                if (step_go)
                begin
                    pc_next = ctrl.target;
                end
            end
            vfv_pkg::JMP_SAME:
            begin
                pc_next = st.same_id ? ctrl.target : pc_reg + 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= vfv_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/voxel_face_visibility_top.sv -----
// ----------------------------------------------------------------------------
// voxel_face_visibility_top: one chunk of voxel ids with face culling
// Write, query and clear items on a stream port; one result word per item.
// ----------------------------------------------------------------------------
// After reset the block fills its voxel memory (ground below layer 23, air
// above), one entry per cycle, 2**(2*clog2(CHUNK_WIDTH)+clog2(CHUNK_HEIGHT))
// entries, 16384 with the default geometry, with s_tready low. Then it takes
// one item at a time. A query reads self plus six neighbors over the two read
// ports of the memory in four steps, then captures and masks before its result
// enters the output register; a write reads, compares and stores only if the
// id differs; a clear, an invalid coordinate or an unused kind gives its
// result in a single step. The sequencer returns to its idle step as a result
// enters the output register and takes the next item from there; a result
// word waiting in the output register holds the result step and so the input.
module voxel_face_visibility_top #(
    parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pos_x[5:0], pos_y[13:6], pos_z[19:14], new_id[27:20]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], voxel_id[9:2], face_mask[15:10], dirty[16]
    output logic [0:0]  m_tuser    // is_water[0]
);

    localparam int XW = $clog2(CHUNK_WIDTH);
    localparam int YW = $clog2(CHUNK_HEIGHT);

    logic [5:0]       in_x;
    logic [7:0]       in_y;
    logic [5:0]       in_z;
    logic [7:0]       in_id;
    logic             accept;
    logic             coord_ok;

    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic [XW-1:0]    z_reg;
    logic [7:0]       id_reg;

    vfv_pkg::seq_in_t st;
    vfv_pkg::ctrl_t   ctrl;
    logic             step_go;

    logic [7:0]       rd_a_data;
    logic             rd_a_bnd;
    logic [7:0]       rd_b_data;
    logic             rd_b_bnd;
    logic             init_busy;

    logic [7:0]       self_id_reg;
    logic [5:0]       nb_bnd_reg;
    logic [5:0]       nb_air_reg;
    logic [5:0]       nb_water_reg;
    logic [5:0]       face_a;
    logic [5:0]       face_b;
    logic [5:0]       exposed;
    logic [5:0]       mask;
    logic             self_water;

    logic             dirty_reg;
    logic             dirty_next;
    logic             emit;
    logic             out_free;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_id_reg;
    logic [5:0]       out_mask_reg;
    logic             out_water_reg;
    logic             out_dirty_reg;
    logic [1:0]       res_status;
    logic [7:0]       res_id;
    logic [5:0]       res_mask;
    logic             res_water;

    // unpack the input word
    assign in_x   = s_tdata[5:0];
    assign in_y   = s_tdata[13:6];
    assign in_z   = s_tdata[19:14];
    assign in_id  = s_tdata[27:20];
    assign accept = s_tvalid && s_tready;

    // coordinate range check on the incoming item
    assign coord_ok = !in_x[5] && (7'(in_x) < 7'(CHUNK_WIDTH))
                   && !in_y[7] && (9'(in_y) < 9'(CHUNK_HEIGHT))
                   && !in_z[5] && (7'(in_z) < 7'(CHUNK_WIDTH));

    // item register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= in_x[XW-1:0];
            y_reg  <= in_y[YW-1:0];
            z_reg  <= in_z[XW-1:0];
            id_reg <= in_id;
        end
    end

    // sequencer status
    assign out_free     = !out_valid_reg || m_tready;
    assign st.accept    = accept;
    assign st.kind      = s_tuser;
    assign st.coord_ok  = coord_ok;
    assign st.same_id   = (rd_a_data == id_reg);
    assign st.out_free  = out_free;
    assign st.init_busy = init_busy;

    vfv_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .ctrl     (ctrl),
        .step_go  (step_go),
        .in_ready (s_tready)
    );

    vfv_store #(
        .CHUNK_WIDTH  (CHUNK_WIDTH),
        .CHUNK_HEIGHT (CHUNK_HEIGHT)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_x     (x_reg),
        .pos_y     (y_reg),
        .pos_z     (z_reg),
        .rd_a_dir  (ctrl.rd_a),
        .rd_b_dir  (ctrl.rd_b),
        .wr_en     (ctrl.wr_en && step_go),
        .wr_data   (id_reg),
        .rd_a_data (rd_a_data),
        .rd_a_bnd  (rd_a_bnd),
        .rd_b_data (rd_b_data),
        .rd_b_bnd  (rd_b_bnd),
        .init_busy (init_busy)
    );

    // capture the self id and neighbor classes read in the previous step
    assign face_a = vfv_pkg::cap_face(ctrl.cap_a);
    assign face_b = vfv_pkg::cap_face(ctrl.cap_b);

    always_ff @(posedge clk)
    begin
        if (step_go && ctrl.cap_a == vfv_pkg::CAP_SELF)
        begin
            self_id_reg <= rd_a_data;
        end
        for (int k = 0; k < 6; k++)
        begin
            if (step_go && face_a[k])
            begin
                nb_bnd_reg[k]   <= rd_a_bnd;
                nb_air_reg[k]   <= (rd_a_data == vfv_pkg::ID_AIR);
                nb_water_reg[k] <= (rd_a_data == vfv_pkg::ID_WATER);
            end
            else if (step_go && face_b[k])
            begin
                nb_bnd_reg[k]   <= rd_b_bnd;
                nb_air_reg[k]   <= (rd_b_data == vfv_pkg::ID_AIR);
                nb_water_reg[k] <= (rd_b_data == vfv_pkg::ID_WATER);
            end
        end
    end

    // face mask: water hides behind water, opaque behind anything but air or water
    assign self_water = (self_id_reg == vfv_pkg::ID_WATER);
    assign exposed    = nb_bnd_reg | (self_water ? ~nb_water_reg : (nb_air_reg | nb_water_reg));
    assign mask       = (self_id_reg == vfv_pkg::ID_AIR) ? 6'b000000 : exposed;

    // dirty flag after this step
    always_comb
    begin
        dirty_next = dirty_reg;
        if (step_go && ctrl.dirty_set)
        begin
            dirty_next = 1'b1;
        end
        else if (step_go && ctrl.dirty_clr)
        begin
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b0;
        end
        else
        begin
            dirty_reg <= dirty_next;
        end
    end

    // result word
    always_comb
    begin
        res_status = vfv_pkg::ST_OK;
        res_id     = 8'd0;
        res_mask   = 6'd0;
        res_water  = 1'b0;
        unique case (ctrl.res)
            vfv_pkg::RES_INV:  res_status = vfv_pkg::ST_INVALID;
            vfv_pkg::RES_NEW:  res_id     = id_reg;
            vfv_pkg::RES_SAME:
            begin
                res_status = vfv_pkg::ST_SAME;
                res_id     = id_reg;
            end
            vfv_pkg::RES_QUERY:
            begin
                res_id    = self_id_reg;
                res_mask  = mask;
                res_water = self_water;
            end
            default:           res_status = vfv_pkg::ST_OK;
        endcase
    end

    // output register
    assign emit = (ctrl.res != vfv_pkg::RES_NONE) && step_go;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_mask_reg   <= res_mask;
            out_water_reg  <= res_water;
            out_dirty_reg  <= dirty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_dirty_reg, out_mask_reg, out_id_reg, out_status_reg};
    assign m_tuser  = out_water_reg;

endmodule

// ----- rtl/vfv_check.sv -----
// ----------------------------------------------------------------------------
// vfv_check: port-level checks for the voxel face visibility block
// Watches the stream ports of the top level; attached by a bind statement.
// ----------------------------------------------------------------------------
module vfv_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one item at a time: no new item right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // an invalid coordinate carries no id, faces or water flag
    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == vfv_pkg::ST_INVALID
        |-> m_tdata[15:2] == 14'd0 && m_tuser == 1'b0)
        else $error("invalid result with payload");

    // faces only on a result with OK status and a non-air voxel id
    a_faces_solid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:10] != 6'd0
        |-> m_tdata[1:0] == vfv_pkg::ST_OK && m_tdata[9:2] != vfv_pkg::ID_AIR)
        else $error("faces reported for air or a failed item");

    // the water flag matches the water id
    a_water_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[9:2] == vfv_pkg::ID_WATER)
        else $error("water flag on a non-water voxel");

endmodule

bind voxel_face_visibility_top vfv_check u_vfv_check (.*);
